[sv/assert_macros.svh]
// assertion macros used by the top-level rtl file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

// when ante holds, cons must hold in the cycle after
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[sv/rwhp_pkg.sv]
// shared types and constants of the riff/wave header parser
// no dependencies
`default_nettype none

package rwhp_pkg;

    localparam int COUNT_BITS_DEF = 33;
    localparam int LIMIT_BITS     = 33;

    // little-endian four-character tags
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TRUNCATED   = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE    = 3'd2;
    localparam logic [2:0] ST_MALFORMED   = 3'd3;
    localparam logic [2:0] ST_NO_FMT      = 3'd4;
    localparam logic [2:0] ST_NO_DATA     = 3'd5;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd6;
    localparam logic [2:0] ST_EMPTY       = 3'd7;

    // header verdicts share the status encoding
    localparam logic [1:0] VERDICT_GOOD  = 2'd0;
    localparam logic [1:0] VERDICT_MAGIC = 2'd2;
    localparam logic [1:0] VERDICT_SIZE  = 2'd3;

    // configuration register indexes
    localparam int          CFG_INDEX_BITS = 2;
    localparam logic [1:0]  CFG_CHANNELS   = 2'd0;
    localparam logic [1:0]  CFG_RATE       = 2'd1;
    localparam logic [1:0]  CFG_BITS       = 2'd2;

    localparam logic [15:0] CHANNELS_RST = 16'd1;
    localparam logic [31:0] RATE_RST     = 32'd22050;
    localparam logic [15:0] BITS_RST     = 16'd8;

    typedef struct packed {
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
    } rwhp_cfg_t;

    // parse state captured on the last byte of a file
    typedef struct packed {
        logic [LIMIT_BITS-1:0] size;
        logic [LIMIT_BITS-1:0] limit;
        logic [1:0]            verdict;
        logic [2:0]            walk_err;
        logic                  fmt_seen;
        logic                  data_seen;
        logic [31:0]           start;
        logic [31:0]           length;
        logic [15:0][7:0]      fmt;
    } rwhp_snap_t;

    typedef struct packed {
        logic snap_valid;
        logic snap_free;
    } rwhp_flow_t;

endpackage

`default_nettype wire

[sv/rwhp_walker.sv]
// byte-by-byte header and chunk walker of the riff/wave parser
// depends on rwhp_pkg
`default_nettype none

module rwhp_walker
    import rwhp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] file_byte,
    input  wire logic       final_byte,
    output rwhp_snap_t      snap
);

    typedef enum logic [2:0] {PH_HEADER, PH_CHUNK, PH_FMT, PH_SKIP, PH_DONE} phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [LIMIT_BITS-1:0] cb;
        logic [LIMIT_BITS-1:0] gap;
        logic                  fail;
    } enter_t;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // arrive at a chunk start p with g bytes left before the riff end
    function automatic enter_t enter_at(input logic [LIMIT_BITS-1:0] p,
                                        input logic [LIMIT_BITS-1:0] g);
        enter_t e;
        e.cb   = p + LIMIT_BITS'(8);
        e.gap  = g - LIMIT_BITS'(8);
        e.fail = 1'b0;
        if (g == '0)
            e.phase = PH_DONE;
        else if (g < LIMIT_BITS'(8))
        begin
            e.phase = PH_DONE;
            e.fail  = 1'b1;
        end
        else
            e.phase = PH_CHUNK;
        return e;
    endfunction

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] seen_reg, seen_next;
    logic [LIMIT_BITS-1:0] limit_reg, limit_next;
    logic [LIMIT_BITS-1:0] cb_reg, cb_next;     // body start in chunk phase, else next chunk
    logic [LIMIT_BITS-1:0] gap_reg, gap_next;   // riff end minus cb
    logic [4:0]            cnt_reg, cnt_next;
    logic [31:0]           word_reg, word_next;
    logic [31:0]           tag_reg, tag_next;
    logic [31:0]           len_reg, len_next;
    logic [15:0][7:0]      fmt_reg, fmt_next;
    logic                  fmt_seen_reg, fmt_seen_next;
    logic                  data_seen_reg, data_seen_next;
    logic [31:0]           start_reg, start_next;
    logic [31:0]           size_reg, size_next;
    logic [1:0]            verdict_reg, verdict_next;
    logic [2:0]            err_reg, err_next;

    always_comb
    begin
        logic [31:0]           shift;
        logic [LIMIT_BITS-1:0] idx;
        logic [LIMIT_BITS-1:0] len33;
        logic [1:0]            hv;
        logic                  is_fmt;
        logic                  odd;
        enter_t                ent;
        logic                  do_enter;

        shift    = {file_byte, word_reg[31:8]};
        idx      = LIMIT_BITS'(seen_reg);
        len33    = LIMIT_BITS'(shift);
        odd      = shift[0];
        is_fmt   = (tag_reg == TAG_FMT) && !fmt_seen_reg;
        hv       = verdict_reg;
        ent      = enter_at(cb_reg, gap_reg);
        do_enter = 1'b0;

        phase_next     = phase_reg;
        seen_next      = seen_reg;
        limit_next     = limit_reg;
        cb_next        = cb_reg;
        gap_next       = gap_reg;
        cnt_next       = cnt_reg;
        word_next      = word_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        fmt_next       = fmt_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        start_next     = start_reg;
        size_next      = size_reg;
        verdict_next   = verdict_reg;
        err_next       = err_reg;

        if (step && (seen_reg != COUNT_MAX))
        begin
            seen_next = seen_reg + COUNT_BITS'(1);
            unique case (phase_reg)
                PH_HEADER:
                begin
                    word_next = shift;
                    if (seen_reg[3:0] == 4'd3 && shift != TAG_RIFF)
                        verdict_next = VERDICT_MAGIC;
                    if (seen_reg[3:0] == 4'd7)
                        len_next = shift;
                    if (seen_reg[3:0] == 4'd11)
                    begin
                        if (shift != TAG_WAVE)
                            hv = VERDICT_MAGIC;
                        if (hv == VERDICT_GOOD && len_reg < 32'd4)
                            hv = VERDICT_SIZE;
                        verdict_next = hv;
                        if (hv != VERDICT_GOOD)
                            phase_next = PH_DONE;
                        else
                        begin
                            limit_next = LIMIT_BITS'(len_reg) + LIMIT_BITS'(8);
                            ent        = enter_at(LIMIT_BITS'(12),
                                                  LIMIT_BITS'(len_reg) - LIMIT_BITS'(4));
                            do_enter   = 1'b1;
                        end
                    end
                end
                PH_CHUNK:
                begin
                    word_next = shift;
                    cnt_next  = cnt_reg + 5'd1;
                    if (cnt_reg == 5'd3)
                        tag_next = shift;
                    if (cnt_reg == 5'd7)
                    begin
                        len_next = shift;
                        if (len33 > gap_reg)
                        begin
                            phase_next = PH_DONE;
                            err_next   = ST_TRUNCATED;
                        end
                        else if (is_fmt && shift < 32'd16)
                        begin
                            phase_next = PH_DONE;
                            err_next   = ST_MALFORMED;
                        end
                        else
                        begin
                            if (is_fmt)
                            begin
                                fmt_seen_next = 1'b1;
                                fmt_next      = '0;
                            end
                            else if (tag_reg == TAG_DATA && !data_seen_reg)
                            begin
                                data_seen_next = 1'b1;
                                start_next     = cb_reg[31:0];
                                size_next      = shift;
                            end
                            // pad byte would land on the riff end
                            if (odd && len33 == gap_reg)
                            begin
                                phase_next = PH_DONE;
                                err_next   = ST_TRUNCATED;
                            end
                            else if (shift == 32'd0)
                                do_enter = 1'b1;
                            else
                            begin
                                cb_next    = cb_reg + len33 + LIMIT_BITS'(odd);
                                gap_next   = gap_reg - len33 - LIMIT_BITS'(odd);
                                cnt_next   = 5'd0;
                                phase_next = is_fmt ? PH_FMT : PH_SKIP;
                            end
                        end
                    end
                end
                PH_FMT, PH_SKIP:
                begin
                    if (phase_reg == PH_FMT && cnt_reg < 5'd16)
                    begin
                        fmt_next[cnt_reg[3:0]] = file_byte;
                        cnt_next = cnt_reg + 5'd1;
                    end
                    if (idx + LIMIT_BITS'(1) == cb_reg)
                        do_enter = 1'b1;
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase

            if (do_enter)
            begin
                phase_next = ent.phase;
                cb_next    = ent.cb;
                gap_next   = ent.gap;
                cnt_next   = 5'd0;
                word_next  = '0;
                if (ent.fail)
                    err_next = ST_MALFORMED;
            end
        end

        snap.size      = LIMIT_BITS'(seen_next);
        snap.limit     = limit_next;
        snap.verdict   = verdict_next;
        snap.walk_err  = err_next;
        snap.fmt_seen  = fmt_seen_next;
        snap.data_seen = data_seen_next;
        snap.start     = start_next;
        snap.length    = size_next;
        snap.fmt       = fmt_next;

        // report taken, start over for the next file
        if (step && final_byte)
        begin
            phase_next     = PH_HEADER;
            seen_next      = '0;
            limit_next     = '0;
            cb_next        = LIMIT_BITS'(12);
            gap_next       = '0;
            cnt_next       = '0;
            word_next      = '0;
            tag_next       = '0;
            len_next       = '0;
            fmt_next       = '0;
            fmt_seen_next  = 1'b0;
            data_seen_next = 1'b0;
            start_next     = '0;
            size_next      = '0;
            verdict_next   = VERDICT_GOOD;
            err_next       = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            seen_reg      <= '0;
            limit_reg     <= '0;
            cb_reg        <= LIMIT_BITS'(12);
            gap_reg       <= '0;
            cnt_reg       <= '0;
            word_reg      <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            fmt_reg       <= '0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            start_reg     <= '0;
            size_reg      <= '0;
            verdict_reg   <= VERDICT_GOOD;
            err_reg       <= ST_OK;
        end
        else
        begin
            phase_reg     <= phase_next;
            seen_reg      <= seen_next;
            limit_reg     <= limit_next;
            cb_reg        <= cb_next;
            gap_reg       <= gap_next;
            cnt_reg       <= cnt_next;
            word_reg      <= word_next;
            tag_reg       <= tag_next;
            len_reg       <= len_next;
            fmt_reg       <= fmt_next;
            fmt_seen_reg  <= fmt_seen_next;
            data_seen_reg <= data_seen_next;
            start_reg     <= start_next;
            size_reg      <= size_next;
            verdict_reg   <= verdict_next;
            err_reg       <= err_next;
        end
    end

endmodule

`default_nettype wire

[sv/rwhp_report.sv]
// snapshot register, status evaluation and result register
// depends on rwhp_pkg
`default_nettype none

module rwhp_report
    import rwhp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        snap_load,
    input  rwhp_snap_t       snap_in,
    input  rwhp_cfg_t        cfg,
    input  wire logic        out_stall,
    output logic             out_valid,
    output logic [2:0]       status,
    output logic [31:0]      payload_offset,
    output logic [31:0]      payload_length,
    output logic [31:0]      rate_found,
    output logic [15:0]      channels_found,
    output logic [15:0]      bits_found,
    output rwhp_flow_t       flow
);

    rwhp_snap_t  snap_reg;
    logic        snap_vld_reg;
    logic        out_free;
    logic        snap_move;

    logic [2:0]  st_next;
    logic [15:0] afmt, chans, align, bits;
    logic [31:0] rate, brate;

    assign out_free  = !out_valid || !out_stall;
    assign snap_move = snap_vld_reg && out_free;

    assign flow.snap_valid = snap_vld_reg;
    assign flow.snap_free  = !snap_vld_reg || snap_move;

    assign afmt  = {snap_reg.fmt[1],  snap_reg.fmt[0]};
    assign chans = {snap_reg.fmt[3],  snap_reg.fmt[2]};
    assign rate  = {snap_reg.fmt[7],  snap_reg.fmt[6],  snap_reg.fmt[5],  snap_reg.fmt[4]};
    assign brate = {snap_reg.fmt[11], snap_reg.fmt[10], snap_reg.fmt[9],  snap_reg.fmt[8]};
    assign align = {snap_reg.fmt[13], snap_reg.fmt[12]};
    assign bits  = {snap_reg.fmt[15], snap_reg.fmt[14]};

    always_comb
    begin
        if (snap_reg.size < LIMIT_BITS'(12))
            st_next = ST_TRUNCATED;
        else if (snap_reg.verdict != VERDICT_GOOD)
            st_next = {1'b0, snap_reg.verdict};
        else if (snap_reg.limit > snap_reg.size)
            st_next = ST_TRUNCATED;
        else if (snap_reg.walk_err != ST_OK)
            st_next = snap_reg.walk_err;
        else if (!snap_reg.fmt_seen)
            st_next = ST_NO_FMT;
        else if (!snap_reg.data_seen)
            st_next = ST_NO_DATA;
        else if (afmt != 16'd1 || chans != cfg.channels || rate != cfg.rate ||
                 bits != cfg.bits || align != 16'd1 || brate != cfg.rate)
            st_next = ST_UNSUPPORTED;
        else if (snap_reg.length == 32'd0)
            st_next = ST_EMPTY;
        else
            st_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_vld_reg   <= 1'b0;
            snap_reg       <= '0;
            out_valid      <= 1'b0;
            status         <= ST_OK;
            payload_offset <= '0;
            payload_length <= '0;
            rate_found     <= '0;
            channels_found <= '0;
            bits_found     <= '0;
        end
        else
        begin
            if (snap_load)
            begin
                snap_reg     <= snap_in;
                snap_vld_reg <= 1'b1;
            end
            else if (snap_move)
                snap_vld_reg <= 1'b0;

            if (snap_move)
            begin
                out_valid      <= 1'b1;
                status         <= st_next;
                payload_offset <= (st_next == ST_OK) ? snap_reg.start  : 32'd0;
                payload_length <= (st_next == ST_OK) ? snap_reg.length : 32'd0;
                rate_found     <= (st_next == ST_OK) ? rate  : 32'd0;
                channels_found <= (st_next == ST_OK) ? chans : 16'd0;
                bits_found     <= (st_next == ST_OK) ? bits  : 16'd0;
            end
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[sv/riff_wave_header_parser.sv]
// top level of the riff/wave header parser: input register, walker, report stage
// depends on rwhp_pkg, rwhp_walker, rwhp_report and assert_macros.svh
// throughput: one file byte per cycle, unless a final byte must wait for the snapshot slot
// an accepted final byte goes through the snapshot register into the result register, which raises out_valid
// a stalled result waits in the output register while bytes of the next file keep flowing
// reset: parse state and pipeline cleared, config regs back to 1 channel, 22050 Hz, 8 bits
`default_nettype none

`include "assert_macros.svh"

module riff_wave_header_parser
    import rwhp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // byte stream
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [7:0]                file_byte,
    input  wire logic                      final_byte,
    // report
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [2:0]                     status,
    output logic [31:0]                    payload_offset,
    output logic [31:0]                    payload_length,
    output logic [31:0]                    rate_found,
    output logic [15:0]                    channels_found,
    output logic [15:0]                    bits_found,
    // configuration writes
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [31:0]               cfg_data
);

    // input register, one byte deep
    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    rwhp_cfg_t  cfg_reg;
    rwhp_snap_t snap;
    rwhp_flow_t flow;

    logic step;
    logic in_free;
    logic fields_zero;

    // a byte moves on unless it ends a file and the snapshot slot is still taken
    assign step     = in_vld_reg && (!last_reg || flow.snap_free);
    assign in_free  = !in_vld_reg || step;
    assign in_stall = !in_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            byte_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else if (in_free)
        begin
            in_vld_reg <= in_valid;
            if (in_valid)
            begin
                byte_reg <= file_byte;
                last_reg <= final_byte;
            end
        end
    end

    // configuration registers; the user must write them only while the block is idle (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channels <= CHANNELS_RST;
            cfg_reg.rate     <= RATE_RST;
            cfg_reg.bits     <= BITS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNELS: cfg_reg.channels <= cfg_data[15:0];
                CFG_RATE:     cfg_reg.rate     <= cfg_data;
                CFG_BITS:     cfg_reg.bits     <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // header check and chunk walk, one byte per step
    rwhp_walker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .file_byte  (byte_reg),
        .final_byte (last_reg),
        .snap       (snap)
    );

    // status precedence and result register
    rwhp_report u_report (
        .clk            (clk),
        .rst_n          (rst_n),
        .snap_load      (step && last_reg),
        .snap_in        (snap),
        .cfg            (cfg_reg),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .payload_offset (payload_offset),
        .payload_length (payload_length),
        .rate_found     (rate_found),
        .channels_found (channels_found),
        .bits_found     (bits_found),
        .flow           (flow)
    );

    // all payload fields of the result register are zero
    assign fields_zero = (payload_offset == 32'd0) && (payload_length == 32'd0) &&
                         (rate_found == 32'd0) && (channels_found == 16'd0) &&
                         (bits_found == 16'd0);

    // a waiting snapshot reaches an empty result register on the next edge
    `ASSERT_NEXT(a_snap_to_out, clk, rst_n, flow.snap_valid && !out_valid, out_valid)

    // a final byte that steps always leaves a snapshot behind
    `ASSERT_NEXT(a_final_makes_snap, clk, rst_n, step && last_reg, flow.snap_valid)

    // only a clean report carries payload fields
    `ASSERT_ALWAYS(a_zero_unless_ok, clk, rst_n, !out_valid || status == ST_OK || fields_zero)

endmodule

`default_nettype wire

[tb/sv/riff_wave_header_parser_tb.sv]
// self-checking testbench of riff_wave_header_parser: directed files, back-pressure, random files
// depends on rwhp_pkg and the riff_wave_header_parser rtl; reads no files
// a built-in byte-level predictor computes the report expected for every file
`default_nettype none

module riff_wave_header_parser_tb;
    import rwhp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // idle tail after the last report has come, with some slack
    localparam int TAIL_CYCLES = 6;
    localparam int RANDOM_BYTES = 600;
    localparam longint unsigned SEEN_MAX = (64'd1 << COUNT_BITS_DEF) - 64'd1;
    // an ordinary chunk the parser has to skip
    localparam logic [31:0] TAG_LIST = 32'h5453_494c;

    typedef enum logic [2:0] {
        WALK_HEADER,
        WALK_CHUNK,
        WALK_FMT,
        WALK_SKIP,
        WALK_DONE
    } walk_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] rate;
        logic [15:0] channels;
        logic [15:0] bits;
    } report_t;

    // clock, reset and block ports; every input is known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  file_byte = 8'd0;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
    logic [31:0] rate_found;
    logic [15:0] channels_found;
    logic [15:0] bits_found;
    logic        cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_CHANNELS;
    logic [31:0] cfg_data = 32'd0;

    always #4 clk = ~clk;

    riff_wave_header_parser DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .file_byte      (file_byte),
        .final_byte     (final_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .payload_offset (payload_offset),
        .payload_length (payload_length),
        .rate_found     (rate_found),
        .channels_found (channels_found),
        .bits_found     (bits_found),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    int fail_count = 0;

    // reports still owed by the block, oldest first
    report_t pending_reports[$];
    report_t oldest_report;

    // file under construction, sent front to back
    logic [7:0] wav_bytes[$];

    // idling control: steady turns off gaps and random stalls,
    // hold_request asks the report side for one long stall
    bit steady = 1'b0;
    int hold_request = 0;
    int hold_left = 0;
    int stall_left = 0;

    // ------------------------------------------------------------------
    // predictor: format expectations and the parse state of the current file
    // ------------------------------------------------------------------
    logic [15:0]     want_channels;
    logic [31:0]     want_rate;
    logic [15:0]     want_bits;

    longint unsigned seen_count;
    longint unsigned riff_bound;
    longint unsigned chunk_edge;
    walk_t           walk;
    logic [31:0]     shift_word;
    logic [31:0]     chunk_tag;
    logic [31:0]     chunk_len;
    logic [63:0]     fmt_body[2];
    bit              fmt_seen;
    bit              data_seen;
    logic [31:0]     data_start;
    logic [31:0]     data_len;
    logic [1:0]      verdict;
    logic [2:0]      walk_err;

    function void clear_parse();
        seen_count  = 0;
        riff_bound  = 0;
        chunk_edge  = 12;
        walk        = WALK_HEADER;
        shift_word  = '0;
        chunk_tag   = '0;
        chunk_len   = '0;
        fmt_body[0] = '0;
        fmt_body[1] = '0;
        fmt_seen    = 1'b0;
        data_seen   = 1'b0;
        data_start  = '0;
        data_len    = '0;
        verdict     = VERDICT_GOOD;
        walk_err    = ST_OK;
    endfunction

    // the first chunk error is kept and the walk stops there
    function void fail_walk(logic [2:0] code);
        walk_err = code;
        walk     = WALK_DONE;
    endfunction

    function void enter_chunk(longint unsigned pos);
        chunk_edge = pos;
        shift_word = '0;
        if (pos >= riff_bound)
            walk = WALK_DONE;
        else if (riff_bound - pos < 8)
            fail_walk(ST_MALFORMED);
        else
            walk = WALK_CHUNK;
    endfunction

    // chunk header complete: decide what happens to its body
    function void close_chunk_header();
        longint unsigned body;
        longint unsigned len;
        longint unsigned nxt;
        bit              is_fmt;
        body   = chunk_edge + 8;
        len    = 64'(chunk_len);
        is_fmt = (chunk_tag == TAG_FMT) && !fmt_seen;
        if (len > riff_bound - body)
        begin
            fail_walk(ST_TRUNCATED);
            return;
        end
        nxt = body + len;
        if (is_fmt && len < 16)
        begin
            fail_walk(ST_MALFORMED);
            return;
        end
        if (is_fmt)
        begin
            fmt_seen    = 1'b1;
            fmt_body[0] = '0;
            fmt_body[1] = '0;
        end
        else if (chunk_tag == TAG_DATA && !data_seen)
        begin
            data_seen  = 1'b1;
            data_start = body[31:0];
            data_len   = chunk_len;
        end
        // odd bodies carry a pad byte, which must still lie inside the riff
        if (len[0])
        begin
            if (nxt == riff_bound)
            begin
                fail_walk(ST_TRUNCATED);
                return;
            end
            nxt++;
        end
        if (nxt == body)
        begin
            enter_chunk(nxt);
            return;
        end
        chunk_edge = nxt;
        walk       = is_fmt ? WALK_FMT : WALK_SKIP;
    endfunction

    function void take_byte(longint unsigned idx, logic [7:0] b);
        longint unsigned off;
        longint unsigned len;
        longint unsigned body;
        case (walk)
            WALK_HEADER:
            begin
                shift_word = {b, shift_word[31:8]};
                if (idx == 3 && shift_word != TAG_RIFF)
                    verdict = VERDICT_MAGIC;
                if (idx == 7)
                    chunk_len = shift_word;
                if (idx == 11)
                begin
                    if (shift_word != TAG_WAVE)
                        verdict = VERDICT_MAGIC;
                    if (verdict == VERDICT_GOOD && chunk_len < 4)
                        verdict = VERDICT_SIZE;
                    if (verdict != VERDICT_GOOD)
                    begin
                        walk = WALK_DONE;
                    end
                    else
                    begin
                        riff_bound = 64'(chunk_len) + 64'd8;
                        enter_chunk(12);
                    end
                end
            end
            WALK_CHUNK:
            begin
                shift_word = {b, shift_word[31:8]};
                off = idx - chunk_edge;
                if (off == 3)
                    chunk_tag = shift_word;
                if (off == 7)
                begin
                    chunk_len = shift_word;
                    close_chunk_header();
                end
            end
            WALK_FMT, WALK_SKIP:
            begin
                if (walk == WALK_FMT)
                begin
                    len  = 64'(chunk_len);
                    body = chunk_edge - len - (len & 64'd1);
                    off  = idx - body;
                    if (off < 16)
                        fmt_body[off[3]] |= 64'(b) << (off[2:0] * 8);
                end
                if (idx + 1 == chunk_edge)
                    enter_chunk(idx + 1);
            end
            default: ;
        endcase
    endfunction

    // report for the file that just ended, in status precedence order
    function void file_report();
        report_t     r;
        logic [15:0] afmt;
        logic [15:0] chans;
        logic [15:0] align;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [2:0]  st;
        afmt  = fmt_body[0][15:0];
        chans = fmt_body[0][31:16];
        rate  = fmt_body[0][63:32];
        brate = fmt_body[1][31:0];
        align = fmt_body[1][47:32];
        bits  = fmt_body[1][63:48];
        if (seen_count < 12)
            st = ST_TRUNCATED;
        else if (verdict != VERDICT_GOOD)
            st = {1'b0, verdict};
        else if (riff_bound > seen_count)
            st = ST_TRUNCATED;
        else if (walk_err != ST_OK)
            st = walk_err;
        else if (!fmt_seen)
            st = ST_NO_FMT;
        else if (!data_seen)
            st = ST_NO_DATA;
        else if (afmt != 16'd1 || chans != want_channels || rate != want_rate ||
                 bits != want_bits || align != 16'd1 || brate != want_rate)
            st = ST_UNSUPPORTED;
        else if (data_len == 0)
            st = ST_EMPTY;
        else
            st = ST_OK;
        r = '0;
        r.status = st;
        if (st == ST_OK)
        begin
            r.offset   = data_start;
            r.length   = data_len;
            r.rate     = rate;
            r.channels = chans;
            r.bits     = bits;
        end
        pending_reports.push_back(r);
    endfunction

    // one accepted byte; the counter saturates and saturated bytes are dropped
    function void predict_byte(logic [7:0] b, bit last);
        if (seen_count < SEEN_MAX)
        begin
            take_byte(seen_count, b);
            seen_count++;
        end
        if (last)
        begin
            file_report();
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------
    // report checking
    // ------------------------------------------------------------------
    function void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // a report is taken at an edge where out_valid is high and out_stall low
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report with none pending: status %0d", status);
                fail_count++;
            end
            else
            begin
                oldest_report = pending_reports.pop_front();
                check_field("status", oldest_report.status, status);
                check_field("payload_offset", oldest_report.offset, payload_offset);
                check_field("payload_length", oldest_report.length, payload_length);
                check_field("rate_found", oldest_report.rate, rate_found);
                check_field("channels_found", oldest_report.channels, channels_found);
                check_field("bits_found", oldest_report.bits, bits_found);
            end
        end
    end

    // mostly no gap, some short ones, a few long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // report side stalls: a requested long hold wins, then random bursts
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (!steady && $urandom_range(0, 3) == 0)
        begin
            stall_left = pick_gap();
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // offer one item and return at the edge that accepts it; valid stays high
    // so a back-to-back item needs no second assignment in the same step
    task send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        file_byte  <= b;
        final_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b, last);
    endtask

    task send_file();
        int i;
        for (i = 0; i < wav_bytes.size(); i++)
            send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
    endtask

    // sender pauses until every pending report has come, plus the latency tail
    task drain_files();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // write enable is left high; the caller lowers it after the last write
    task write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_CHANNELS: want_channels = val[15:0];
            CFG_RATE:     want_rate = val;
            CFG_BITS:     want_bits = val[15:0];
            default: ;
        endcase
    endtask

    // only while idle; junk in the upper half of the 16-bit registers must be dropped
    task set_format(input logic [15:0] chans, input logic [31:0] rate,
                    input logic [15:0] bits);
        drain_files();
        write_reg(CFG_CHANNELS, {16'($urandom), chans});
        write_reg(CFG_RATE, rate);
        write_reg(CFG_BITS, {16'($urandom), bits});
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // file building
    // ------------------------------------------------------------------
    function void put_word(longint unsigned v, int n);
        int i;
        for (i = 0; i < n; i++)
            wav_bytes.push_back(8'(v >> (8 * i)));
    endfunction

    function void put_random(int n);
        int i;
        for (i = 0; i < n; i++)
            wav_bytes.push_back(8'($urandom));
    endfunction

    function void start_file(logic [31:0] magic, logic [31:0] form);
        wav_bytes.delete();
        put_word(magic, 4);
        put_word(0, 4);
        put_word(form, 4);
    endfunction

    function void set_riff_word(logic [31:0] n);
        wav_bytes[4] = n[7:0];
        wav_bytes[5] = n[15:8];
        wav_bytes[6] = n[23:16];
        wav_bytes[7] = n[31:24];
    endfunction

    // riff length from the bytes so far, shifted by delta
    function void close_riff(int delta);
        set_riff_word(32'(wav_bytes.size() - 8 + delta));
    endfunction

    // chunk with random body and its pad byte
    function void put_chunk(logic [31:0] tag, int len);
        put_word(tag, 4);
        put_word(len, 4);
        put_random(len + (len % 2));
    endfunction

    function void put_fmt(int len, logic [15:0] code, logic [15:0] chans,
                          logic [31:0] rate, logic [31:0] brate,
                          logic [15:0] align, logic [15:0] bits);
        logic [127:0] f;
        int           i;
        f = {bits, align, brate, rate, chans, code};
        put_word(TAG_FMT, 4);
        put_word(len, 4);
        for (i = 0; i < len; i++)
            wav_bytes.push_back(i < 16 ? f[i*8 +: 8] : 8'($urandom));
        if (len % 2)
            put_random(1);
    endfunction

    function void good_fmt();
        put_fmt(16, 16'd1, want_channels, want_rate, want_rate, 16'd1, want_bits);
    endfunction

    // mostly well-formed files with random content; some noise, some damage
    function void build_random_file();
        int          kind;
        int          dlen;
        int          flen;
        int          keep;
        bit          fmt_first;
        logic [7:0]  spare;
        logic [15:0] code;
        logic [15:0] chans;
        logic [15:0] align;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [31:0] brate;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            // noise, sometimes opening with the right magic
            wav_bytes.delete();
            if ($urandom_range(0, 1))
                put_word(TAG_RIFF, 4);
            put_random($urandom_range(1, 24));
            return;
        end
        start_file(TAG_RIFF, TAG_WAVE);
        if ($urandom_range(0, 3) == 0)
            put_chunk($urandom_range(0, 1) ? TAG_LIST : 32'($urandom), $urandom_range(0, 9));
        fmt_first = ($urandom_range(0, 4) != 0);
        dlen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        if (!fmt_first)
            put_chunk(TAG_DATA, dlen);
        code  = 16'd1;
        chans = want_channels;
        rate  = want_rate;
        brate = want_rate;
        align = 16'd1;
        bits  = want_bits;
        if ($urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 5))
                0: code  ^= 16'($urandom_range(1, 65535));
                1: chans ^= 16'($urandom_range(1, 65535));
                2: rate  ^= 32'($urandom_range(1, 65535)) << $urandom_range(0, 16);
                3: brate ^= 32'($urandom_range(1, 65535)) << $urandom_range(0, 16);
                4: align ^= 16'($urandom_range(1, 65535));
                default: bits ^= 16'($urandom_range(1, 65535));
            endcase
        end
        if ($urandom_range(0, 29) == 0)
            flen = $urandom_range(0, 15);
        else if ($urandom_range(0, 8) == 0)
            flen = $urandom_range(17, 21);
        else
            flen = 16;
        put_fmt(flen, code, chans, rate, brate, align, bits);
        if (fmt_first)
            put_chunk(TAG_DATA, dlen);
        if ($urandom_range(0, 5) == 0)
            put_chunk($urandom_range(0, 1) ? TAG_DATA : TAG_FMT, $urandom_range(0, 5));
        if ($urandom_range(0, 9) == 0)
            close_riff(int'($urandom_range(0, 6)) - 3);
        else
            close_riff(0);
        if ($urandom_range(0, 5) == 0)
            put_random($urandom_range(1, 3));
        if ($urandom_range(0, 99) < 12)
            wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 99) < 8)
        begin
            keep = $urandom_range(1, wav_bytes.size());
            while (wav_bytes.size() > keep)
                spare = wav_bytes.pop_back();
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // well-formed files, odd data with pad, chunk order, extras and trailing bytes
    task test_good_files();
        start_file(TAG_RIFF, TAG_WAVE);
        good_fmt();
        put_chunk(TAG_DATA, 3);
        close_riff(0);
        send_file();

        // data before fmt, a zero-length chunk, a longer fmt, a second fmt and data
        // that must be ignored, then bytes past the riff end
        start_file(TAG_RIFF, TAG_WAVE);
        put_chunk(TAG_LIST, 0);
        put_chunk(TAG_DATA, 5);
        put_chunk(TAG_LIST, 1);
        put_fmt(18, 16'd1, want_channels, want_rate, want_rate, 16'd1, want_bits);
        put_fmt(16, 16'd3, 16'd9, 32'd1, 32'd1, 16'd4, 16'd32);
        put_chunk(TAG_DATA, 2);
        close_riff(0);
        put_word(64'hFF00_FF00, 3);
        send_file();
    endtask

    // short files, bad magic words, bad riff size, riff end beyond the file
    task test_header_checks();
        wav_bytes.delete();
        wav_bytes.push_back(8'hFF);
        send_file();

        // eleven bytes of an otherwise fine header
        wav_bytes.delete();
        put_word(TAG_RIFF, 4);
        put_word(40, 4);
        put_word(TAG_WAVE, 3);
        send_file();

        // short beats bad magic
        wav_bytes.delete();
        put_word(32'h5846_4952, 4);
        put_word(0, 4);
        send_file();

        start_file(32'h5846_4952, TAG_WAVE);
        good_fmt();
        close_riff(0);
        send_file();

        start_file(TAG_RIFF, 32'h4656_4157);
        close_riff(0);
        send_file();

        // riff length below four, then exactly four with no chunks at all
        start_file(TAG_RIFF, TAG_WAVE);
        set_riff_word(32'd3);
        send_file();

        start_file(TAG_RIFF, TAG_WAVE);
        set_riff_word(32'd0);
        send_file();

        start_file(TAG_RIFF, TAG_WAVE);
        set_riff_word(32'd4);
        send_file();

        start_file(TAG_RIFF, TAG_WAVE);
        good_fmt();
        put_chunk(TAG_DATA, 4);
        close_riff(10);
        send_file();
    endtask

    // chunk walk errors
    task test_walk_errors();
        // too few bytes left for a chunk header
        start_file(TAG_RIFF, TAG_WAVE);
        good_fmt();
        put_random(5);
        close_riff(0);
        send_file();

        // chunk body runs past the riff end
        start_file(TAG_RIFF, TAG_WAVE);
        good_fmt();
        put_word(TAG_DATA, 4);
        put_word(100, 4);
        put_random(6);
        close_riff(0);
        send_file();

        // first fmt chunk too short
        start_file(TAG_RIFF, TAG_WAVE);
        put_fmt(14, 16'd1, want_channels, want_rate, want_rate, 16'd1, want_bits);
        put_chunk(TAG_DATA, 4);
        close_riff(0);
        send_file();

        // odd chunk whose pad byte would sit at the riff end
        start_file(TAG_RIFF, TAG_WAVE);
        good_fmt();
        put_word(TAG_DATA, 4);
        put_word(3, 4);
        put_random(3);
        close_riff(0);
        send_file();
    endtask

    // format checks, missing chunks and empty data
    task test_format_checks();
        int i;
        logic [15:0] code;
        logic [15:0] chans;
        logic [15:0] align;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [31:0] brate;
        // each fmt field wrong in turn
        for (i = 0; i < 6; i++)
        begin
            code  = (i == 0) ? 16'd3 : 16'd1;
            chans = (i == 1) ? want_channels + 16'd1 : want_channels;
            rate  = (i == 2) ? want_rate + 32'd1 : want_rate;
            brate = (i == 3) ? want_rate + 32'd1 : want_rate;
            align = (i == 4) ? 16'd2 : 16'd1;
            bits  = (i == 5) ? want_bits + 16'd1 : want_bits;
            start_file(TAG_RIFF, TAG_WAVE);
            put_fmt(16, code, chans, rate, brate, align, bits);
            put_chunk(TAG_DATA, 2);
            close_riff(0);
            send_file();
        end

        start_file(TAG_RIFF, TAG_WAVE);
        put_chunk(TAG_DATA, 4);
        close_riff(0);
        send_file();

        start_file(TAG_RIFF, TAG_WAVE);
        good_fmt();
        put_chunk(TAG_LIST, 2);
        close_riff(0);
        send_file();

        start_file(TAG_RIFF, TAG_WAVE);
        good_fmt();
        put_chunk(TAG_DATA, 0);
        close_riff(0);
        send_file();
    endtask

    // register extremes and a common setting, each followed by a matching and a mismatching file
    task test_config_extremes();
        int i;
        for (i = 0; i < 3; i++)
        begin
            case (i)
                0: set_format(16'hFFFF, 32'd0, 16'd1);
                1: set_format(16'd1, 32'hFFFF_FFFF, 16'hFFFF);
                default: set_format(16'd2, 32'd44100, 16'd16);
            endcase
            start_file(TAG_RIFF, TAG_WAVE);
            good_fmt();
            put_chunk(TAG_DATA, 6);
            close_riff(0);
            send_file();

            start_file(TAG_RIFF, TAG_WAVE);
            put_fmt(16, 16'd1, want_channels, ~want_rate, want_rate, 16'd1, want_bits);
            put_chunk(TAG_DATA, 6);
            close_riff(0);
            send_file();
        end
    endtask

    // long report stall while short files keep coming, so the block
    // backs up and stalls its input; then wait for everything to drain
    task test_backpressure();
        int i;
        drain_files();
        steady       = 1'b1;
        hold_request = 200;
        start_file(TAG_RIFF, TAG_WAVE);
        good_fmt();
        put_chunk(TAG_DATA, 1);
        close_riff(0);
        send_file();
        for (i = 0; i < 24; i++)
        begin
            wav_bytes.delete();
            wav_bytes.push_back((i % 2) ? 8'h00 : 8'hFF);
            send_file();
        end
        steady = 1'b0;
        drain_files();
    endtask

    task test_random_files();
        int sent;
        int files;
        sent  = 0;
        files = 0;
        while (sent < RANDOM_BYTES)
        begin
            // a fresh register setting every few files
            if (files % 8 == 0)
            begin
                case ($urandom_range(0, 5))
                    0: set_format(CHANNELS_RST, RATE_RST, BITS_RST);
                    1: set_format(16'd1, 32'd0, 16'd1);
                    2: set_format(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
                    3: set_format(16'($urandom_range(1, 65535)), $urandom,
                                  16'($urandom_range(1, 65535)));
                    default: set_format(16'($urandom_range(1, 8)),
                                        $urandom_range(0, 1) ? 32'd44100 : 32'd8000,
                                        16'(8 * $urandom_range(1, 4)));
                endcase
            end
            // some stretches without any idling
            steady = ($urandom_range(0, 5) == 0);
            build_random_file();
            sent += wav_bytes.size();
            send_file();
            files++;
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        want_channels = CHANNELS_RST;
        want_rate     = RATE_RST;
        want_bits     = BITS_RST;
        clear_parse();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_good_files();
        test_header_checks();
        test_walk_errors();
        test_format_checks();
        test_config_extremes();
        test_backpressure();
        test_random_files();

        drain_files();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[riff_wave_header_parser.f]
+incdir+sv
sv/rwhp_pkg.sv
sv/rwhp_walker.sv
sv/rwhp_report.sv
sv/riff_wave_header_parser.sv
tb/sv/riff_wave_header_parser_tb.sv
